// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define TWDHE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// condition must never be seen outside reset
`define TWDHE_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

// ===== design/twdhe_pkg.sv =====
// types and constants of the two-wire debug host engine
`default_nettype none

package twdhe_pkg;

  // input operation codes
  typedef enum logic [2:0] {
    OP_ADDR_WRITE = 3'd0,
    OP_ADDR_READ  = 3'd1,
    OP_DATA_WRITE = 3'd2,
    OP_DATA_READ  = 3'd3,
    OP_SAMPLE     = 3'd4
  } op_e;

  // transaction phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_READ = 2'd2
  } phase_e;

  // instruction codes sent on the link, lsb first
  localparam logic [1:0] INS_DATA_READ  = 2'd0;
  localparam logic [1:0] INS_DATA_WRITE = 2'd1;
  localparam logic [1:0] INS_ADDR_READ  = 2'd2;
  localparam logic [1:0] INS_ADDR_WRITE = 2'd3;

  // length field of data operations
  localparam logic [1:0] LEN_ONE_BYTE = 2'd0;

  localparam int unsigned SEQ_W = 13;
  localparam int unsigned CNT_W = 4;

  // strobes per request or sample, final strobe included
  localparam logic [CNT_W-1:0] N_ADDR_WRITE = 4'd12;
  localparam logic [CNT_W-1:0] N_ADDR_READ  = 4'd4;
  localparam logic [CNT_W-1:0] N_DATA_WRITE = 4'd14;
  localparam logic [CNT_W-1:0] N_DATA_READ  = 4'd6;
  localparam logic [CNT_W-1:0] N_SAMPLE     = 4'd1;

  localparam logic [3:0] READ_BITS = 4'd8;

  // link transaction state
  typedef struct packed {
    phase_e     phase;
    logic [1:0] cur_op;
    logic [3:0] bit_count;
    logic [7:0] read_shift;
  } state_t;

  // strobe burst caused by one item
  typedef struct packed {
    logic             emit;
    logic [SEQ_W-1:0] seq;
    logic [CNT_W-1:0] count;
    logic             fin_en;
    logic             fin_done;
    logic [7:0]       fin_rb;
  } burst_t;

endpackage

`default_nettype wire

// ===== design/twdhe_decode.sv =====
// per-item decode: strobe burst and next link state
`default_nettype none

module twdhe_decode
  import twdhe_pkg::*;
(
  input  wire logic [2:0] operation_i,
  input  wire logic [7:0] byte_value_i,
  input  wire logic       sampled_bit_i,
  input  wire state_t     cur_i,
  output state_t          nxt_o,
  output burst_t          burst_o
);

  logic [3:0] bc_inc;
  logic [7:0] rs_shift;

  assign bc_inc   = cur_i.bit_count + 4'd1;
  assign rs_shift = {sampled_bit_i, cur_i.read_shift[7:1]};

  always_comb begin
    nxt_o   = cur_i;
    burst_o = '0;
    unique case (op_e'(operation_i))
      OP_ADDR_WRITE, OP_ADDR_READ, OP_DATA_WRITE, OP_DATA_READ: begin
        if (cur_i.phase == PH_IDLE) begin
          burst_o.emit     = 1'b1;
          nxt_o.cur_op     = operation_i[1:0];
          nxt_o.bit_count  = '0;
          nxt_o.read_shift = '0;
          unique case (op_e'(operation_i))
            OP_ADDR_WRITE: begin
              burst_o.seq      = {2'b00, byte_value_i, INS_ADDR_WRITE, 1'b0};
              burst_o.count    = N_ADDR_WRITE;
              burst_o.fin_en   = 1'b1;
              burst_o.fin_done = 1'b1;
              nxt_o.phase      = PH_IDLE;
            end
            OP_ADDR_READ: begin
              burst_o.seq   = {10'd0, INS_ADDR_READ, 1'b0};
              burst_o.count = N_ADDR_READ;
              nxt_o.phase   = PH_READ;
            end
            OP_DATA_WRITE: begin
              burst_o.seq   = {byte_value_i, LEN_ONE_BYTE, INS_DATA_WRITE, 1'b0};
              burst_o.count = N_DATA_WRITE;
              nxt_o.phase   = PH_WAIT;
            end
            default: begin
              burst_o.seq   = {8'd0, LEN_ONE_BYTE, INS_DATA_READ, 1'b0};
              burst_o.count = N_DATA_READ;
              nxt_o.phase   = PH_WAIT;
            end
          endcase
        end
      end
      OP_SAMPLE: begin
        unique case (cur_i.phase)
          // waiting for the target to signal ready
          PH_WAIT: begin
            burst_o.emit  = 1'b1;
            burst_o.count = N_SAMPLE;
            if (sampled_bit_i) begin
              if (cur_i.cur_op == 2'(OP_DATA_WRITE)) begin
                burst_o.fin_en   = 1'b1;
                burst_o.fin_done = 1'b1;
                nxt_o.phase      = PH_IDLE;
              end else begin
                nxt_o.phase      = PH_READ;
                nxt_o.bit_count  = '0;
                nxt_o.read_shift = '0;
              end
            end
          end
          // shifting in read data, lsb first
          PH_READ: begin
            burst_o.emit     = 1'b1;
            burst_o.count    = N_SAMPLE;
            nxt_o.read_shift = rs_shift;
            nxt_o.bit_count  = bc_inc;
            if (bc_inc >= READ_BITS) begin
              burst_o.fin_en   = 1'b1;
              burst_o.fin_done = 1'b1;
              burst_o.fin_rb   = rs_shift;
              nxt_o.phase      = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/two_wire_debug_host_engine.sv =====
// top level of the two-wire debug host engine
// Usage: the input channel takes one item per beat: a request (address write,
// address read, data write, data read) or a line sample. Each accepted item
// yields zero or more strobe beats on the output channel, one per cycle while
// out_ready_i is high, the last one flagged by run_last_o. Requests while
// idle give 4 to 14 strobes, a sample while a transaction is open gives
// exactly one, ignored items give none. The first strobe of an item passes
// the input register and then the strobe register before it is offered.
// One further item is held in the input register while a burst is sent.
// Reset clears the link state to idle and drops any pending item or burst.
// A stall on the output holds the current strobe unchanged; the input
// register then fills and in_ready_o falls until strobes drain.
`default_nettype none

module two_wire_debug_host_engine
  import twdhe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [2:0] operation_i,
  input  wire logic [7:0] byte_value_i,
  input  wire logic       sampled_bit_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            drive_enable_o,
  output logic            drive_value_o,
  output logic [7:0]      read_byte_o,
  output logic            transaction_done_o,
  output logic            run_last_o
);

  logic             s1_valid_q;
  logic [2:0]       s1_op_q;
  logic [7:0]       s1_byte_q;
  logic             s1_bit_q;
  state_t           state_q, state_d;
  burst_t           burst;
  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SEQ_W-1:0] seq_q;
  logic             fin_en_q;
  logic             fin_done_q;
  logic [7:0]       fin_rb_q;
  logic             is_last;
  logic             out_fire;
  logic             emit_free;
  logic             s1_consume;
  logic             load;

  // decode of the held item
  twdhe_decode u_decode (
    .operation_i   (s1_op_q),
    .byte_value_i  (s1_byte_q),
    .sampled_bit_i (s1_bit_q),
    .cur_i         (state_q),
    .nxt_o         (state_d),
    .burst_o       (burst)
  );

  // handshake control
  assign is_last    = (cnt_q == N_SAMPLE);
  assign out_fire   = busy_q && out_ready_i;
  assign emit_free  = !busy_q || (out_ready_i && is_last);
  assign s1_consume = s1_valid_q && (!burst.emit || emit_free);
  assign load       = s1_consume && burst.emit;
  assign in_ready_o = !s1_valid_q || s1_consume;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_op_q   <= operation_i;
      s1_byte_q <= byte_value_i;
      s1_bit_q  <= sampled_bit_i;
    end
  end

  // link state, advanced once per consumed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, cur_op: 2'd0, bit_count: 4'd0, read_shift: 8'd0};
    end else if (s1_consume) begin
      state_q <= state_d;
    end
  end

  // strobe register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      cnt_q  <= burst.count;
    end else if (out_fire) begin
      if (is_last) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - N_SAMPLE;
      end
    end
  end

  // strobe register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      seq_q      <= burst.seq;
      fin_en_q   <= burst.fin_en;
      fin_done_q <= burst.fin_done;
      fin_rb_q   <= burst.fin_rb;
    end else if (out_fire && !is_last) begin
      seq_q <= {1'b0, seq_q[SEQ_W-1:1]};
    end
  end

  // output beat
  assign out_valid_o        = busy_q;
  assign drive_enable_o     = is_last ? fin_en_q : 1'b1;
  assign drive_value_o      = is_last ? 1'b0 : seq_q[0];
  assign read_byte_o        = is_last ? fin_rb_q : 8'd0;
  assign transaction_done_o = is_last && fin_done_q;
  assign run_last_o         = is_last;

endmodule

`default_nettype wire

// ===== design/twdhe_checker.sv =====
// port-level checker for the two-wire debug host engine, with its bind
`default_nettype none
`include "assert_macros.svh"

module twdhe_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic [2:0] operation_i,
  input wire logic [7:0] byte_value_i,
  input wire logic       sampled_bit_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       drive_enable_o,
  input wire logic       drive_value_o,
  input wire logic [7:0] read_byte_o,
  input wire logic       transaction_done_o,
  input wire logic       run_last_o
);

  logic unused_in;
  assign unused_in = in_valid_i ^ in_ready_o ^ (^operation_i) ^ (^byte_value_i)
                     ^ sampled_bit_i;

  // stalled beat holds
  `TWDHE_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_enable_o) && $stable(drive_value_o) && $stable(read_byte_o) && $stable(transaction_done_o) && $stable(run_last_o))
  // stop strobe is a driven zero that closes the item
  `TWDHE_NEVER(a_stop_shape, clk_i, rst_ni, out_valid_o && transaction_done_o && !(drive_enable_o && !drive_value_o && run_last_o))
  // released strobe always ends an item and drives nothing
  `TWDHE_ASSERT(a_release_last, clk_i, rst_ni, out_valid_o && !drive_enable_o |-> run_last_o && !drive_value_o && !transaction_done_o)
  // read byte only travels with the stop strobe
  `TWDHE_ASSERT(a_byte_on_stop, clk_i, rst_ni, out_valid_o && (read_byte_o != 8'd0) |-> transaction_done_o)

endmodule

bind two_wire_debug_host_engine twdhe_checker u_twdhe_checker (.*);

`default_nettype wire
